FILE: rtl/core/epwr_pkg.sv
// Shared types and constants for the echo pulse width ranger.
// No dependencies; imported by every module in rtl/core.
package epwr_pkg;

    localparam int COUNTER_BITS  = 16;
    localparam int OVERFLOW_BITS = 6;
    localparam int TOTAL_W       = OVERFLOW_BITS + COUNTER_BITS;
    localparam int SCALE_W       = 10;
    localparam int PROD_W        = TOTAL_W + SCALE_W;
    localparam int DIST_W        = 23;

    localparam logic [SCALE_W-1:0]       SCALE_RESET = SCALE_W'(170);
    localparam logic [OVERFLOW_BITS-1:0] OVF_MAX     = '1;
    localparam logic [COUNTER_BITS-1:0]  CNT_FULL    = '1;

    // floor(p / 1000) == (p * RECIP_M) >> RECIP_SHIFT for every p below 2^32:
    // RECIP_M * 1000 - 2^41 = 448, which stays under 2^(41-32).
    localparam int               RECIP_SHIFT = 41;
    localparam int               RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP_M   = 32'd2199023256;

    typedef struct packed {
        logic                    overflow_event;
        logic                    capture_event;
        logic [COUNTER_BITS-1:0] captured_count;
        logic                    read_request;
    } t_in_beat;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              new_distance;
        logic              timed_out;
        logic              measurement_ready;
        logic              expect_falling;
    } t_out_beat;

    // Per-item status handed from the tracker to the conversion pipeline.
    typedef struct packed {
        logic               fresh;
        logic               timed_out;
        logic               ready;
        logic               expect_falling;
        logic [TOTAL_W-1:0] total;
    } t_snap;

endpackage

FILE: rtl/core/epwr_track.sv
// Measurement tracker: edge arming, overflow counting, timeout and read.
// Depends on epwr_pkg.
module epwr_track import epwr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_beat i_beat,
    output t_snap    o_snap
);

    logic                     r_done, r_high, r_tmo_pend, r_tmo_flag;
    logic [OVERFLOW_BITS-1:0] r_ovf_cnt;
    logic [COUNTER_BITS-1:0]  r_pulse;

    logic                     n_done, n_high, n_tmo_pend, n_tmo_flag, n_fresh;
    logic [OVERFLOW_BITS-1:0] n_ovf_cnt;
    logic [COUNTER_BITS-1:0]  n_pulse;
    logic [TOTAL_W-1:0]       n_total;

    always_comb begin
        n_done     = r_done;
        n_high     = r_high;
        n_tmo_pend = r_tmo_pend;
        n_tmo_flag = r_tmo_flag;
        n_ovf_cnt  = r_ovf_cnt;
        n_pulse    = r_pulse;
        n_fresh    = 1'b0;

        // overflow while high; at the limit the pulse ends as a timeout
        if (!n_done && i_beat.overflow_event && n_high) begin
            if (n_ovf_cnt == OVF_MAX) begin
                n_pulse    = CNT_FULL;
                n_done     = 1'b1;
                n_tmo_pend = 1'b1;
            end else begin
                n_ovf_cnt = n_ovf_cnt + 1'b1;
            end
        end

        // capture: falling edge completes, rising edge arms
        if (!n_done && i_beat.capture_event) begin
            if (n_high) begin
                n_pulse    = i_beat.captured_count;
                n_done     = 1'b1;
                n_tmo_pend = 1'b0;
            end else begin
                n_high     = 1'b1;
                n_ovf_cnt  = '0;
                n_pulse    = '0;
                n_tmo_pend = 1'b0;
            end
        end

        n_total = {n_ovf_cnt, n_pulse};

        if (i_beat.read_request && n_done) begin
            n_fresh    = 1'b1;
            n_tmo_flag = n_tmo_pend;
            n_done     = 1'b0;
            n_high     = 1'b0;
            n_ovf_cnt  = '0;
            n_tmo_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= 1'b0;
            r_high     <= 1'b0;
            r_tmo_pend <= 1'b0;
            r_tmo_flag <= 1'b0;
            r_ovf_cnt  <= '0;
            r_pulse    <= '0;
        end else if (i_step) begin
            r_done     <= n_done;
            r_high     <= n_high;
            r_tmo_pend <= n_tmo_pend;
            r_tmo_flag <= n_tmo_flag;
            r_ovf_cnt  <= n_ovf_cnt;
            r_pulse    <= n_pulse;
        end
    end

    assign o_snap.fresh          = n_fresh;
    assign o_snap.timed_out      = n_tmo_flag;
    assign o_snap.ready          = n_done;
    assign o_snap.expect_falling = n_high & ~n_done;
    assign o_snap.total          = n_total;

endmodule

FILE: rtl/core/epwr_conv.sv
// Count-to-distance conversion: scale multiply, registered, then the
// reciprocal multiply that divides by 1000. Depends on epwr_pkg.
module epwr_conv import epwr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [TOTAL_W-1:0] i_total,
    input  logic [SCALE_W-1:0] i_scale,
    output logic [DIST_W-1:0]  o_quot
);

    logic [PROD_W-1:0]          r_prod;
    logic [PROD_W+RECIP_W-1:0]  w_wide;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PROD_W'(i_total) * PROD_W'(i_scale);
        end
    end

    assign w_wide = (PROD_W+RECIP_W)'(r_prod) * (PROD_W+RECIP_W)'(RECIP_M);
    // largest quotient is 4290771, so the 23-bit slice never clips
    assign o_quot = w_wide[RECIP_SHIFT +: DIST_W];

endmodule

FILE: rtl/core/echo_pulse_width_ranger.sv
// Echo pulse width ranger, top level: input register, tracker, conversion
// pipeline and output register. Depends on epwr_pkg, epwr_track, epwr_conv.
//
// Usage:
//   Input channel  i_valid / o_stall / i_item: one beat carries timer events
//   (overflow, edge capture with count, read request) handled in that order.
//   Output channel o_valid / i_stall / o_result: exactly one result beat per
//   input beat, in order.
//   Configuration: i_cfg_we writes i_cfg_wdata into the distance scale; write
//   it only while no beat is in flight.
// Pipeline: three register stages (input, scale product, output); o_valid
//   rises once the beat has passed through all three.
// Throughput: one beat per cycle while i_stall is low; the tracker state
//   updates as a beat leaves the input register, and the two multipliers
//   sit in separate stages so the next beat never waits on a conversion.
// Reset (synchronous, active low): all measurement state clears, the held
//   distance clears to 0 and the scale returns to 170; the pipeline empties.
// Receiver stall: the result holds on o_result; each stage still fills its
//   bubble, and o_stall rises once the input register cannot move on.
module echo_pulse_width_ranger import epwr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in_beat           i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out_beat          o_result,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata
);

    logic [SCALE_W-1:0] r_scale;

    // stage 1: input register
    logic     r_v1;
    t_in_beat r_in1;
    // stage 2: status snapshot alongside the product register in epwr_conv
    logic     r_v2;
    t_snap    r_snap2;
    // stage 3: output register and last distance
    logic              r_v3;
    t_out_beat         r_out;
    logic [DIST_W-1:0] r_dist;

    logic              w_en1, w_en2, w_en3, w_step;
    t_snap             w_snap;
    logic [DIST_W-1:0] w_quot, w_dist;

    assign w_en3  = !r_v3 || !i_stall;
    assign w_en2  = !r_v2 || w_en3;
    assign w_en1  = !r_v1 || w_en2;
    assign w_step = r_v1 && w_en2;

    assign o_stall  = !w_en1;
    assign o_valid  = r_v3;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    epwr_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_beat  (r_in1),
        .o_snap  (w_snap)
    );

    epwr_conv u_conv (
        .i_clk   (i_clk),
        .i_load  (w_step),
        .i_total (w_snap.total),
        .i_scale (r_scale),
        .o_quot  (w_quot)
    );

    // a read of a finished measurement shows the new quotient; any other beat repeats the held value
    assign w_dist = r_snap2.fresh ? w_quot : r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_dist <= '0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
                if (r_v2 && r_snap2.fresh) begin
                    r_dist <= w_quot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_in1 <= i_item;
        end
        if (w_step) begin
            r_snap2 <= w_snap;
        end
        if (w_en3 && r_v2) begin
            r_out.distance          <= w_dist;
            r_out.new_distance      <= r_snap2.fresh;
            r_out.timed_out         <= r_snap2.timed_out;
            r_out.measurement_ready <= r_snap2.ready;
            r_out.expect_falling    <= r_snap2.expect_falling;
        end
    end

endmodule
